>>> hdl/pq_pkg.sv
// Shared types and codes for the min-first priority queue.
// Used by pq_cell and min_priority_queue; depends on nothing else.
package pq_pkg;

    // Opcodes of an input request.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One stored pair.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   ext;
        entry_t data;
    } cmd_t;

endpackage

>>> hdl/pq_cell.sv
// One slot of the sorted shift chain: holds a pair and moves it left or right.
// Depends on pq_pkg for entry_t and cmd_t.
module pq_cell
    import pq_pkg::*;
(
    input  logic   clk,
    input  cmd_t   cmd,
    input  logic   here_valid,
    input  logic   left_keep,
    input  entry_t left_entry,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied slot whose priority is not worse than the new one stays put,
    // which keeps equal priorities in arrival order.
    assign keep  = here_valid && (entry_reg.prio <= cmd.data.prio);
    assign entry = entry_reg;

    // Insert opens a gap right after the last kept slot; extract shifts left.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? cmd.data : left_entry;
            end
        end
        else if (cmd.ext)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> hdl/min_priority_queue.sv
// Top level of the min-first priority queue: a sorted chain of pq_cell slots,
// the occupancy counter and the result register. Depends on pq_pkg and pq_cell.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | opcode, item_value, item_priority
//   out     | out_valid,out_stall| out_value, out_priority, status, occupancy
//
// Each request is served in place: the chain is kept sorted, so the head cell
// always holds the answer and every cell shifts in parallel on acceptance.
// The result is registered and appears in the cycle after acceptance, and a new
// request is taken every cycle while the result register is free or being drained.
// Reset clears the occupancy count and the result valid; stored pairs are
// not cleared. A stalled result holds and stalls the input side.
module min_priority_queue
    import pq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] item_value,
    input  logic signed [15:0] item_priority,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_value,
    output logic signed [15:0] out_priority,
    output logic [1:0]         status,
    output logic [4:0]         occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic signed [15:0] prio_reg;
    logic signed [15:0] prio_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [4:0]         occ_reg;

    logic   accept;
    logic   full;
    logic   empty;
    cmd_t   cmd;
    entry_t cell_entry [CAPACITY];
    logic   cell_keep  [CAPACITY];

    // Input side is free whenever the result register can take a new result.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Command broadcast to the chain; rejected requests leave it untouched.
    always_comb
    begin
        cmd.ins        = accept && (opcode == OP_INSERT) && !full;
        cmd.ext        = accept && (opcode == OP_EXTRACT) && !empty;
        cmd.data.value = item_value;
        cmd.data.prio  = item_priority;
    end

    // The chain of cells; slot 0 is the head and holds the best pair.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   here_valid;
        logic   left_keep;
        entry_t left_entry;
        entry_t right_entry;

        assign here_valid = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = cmd.data;
        end
        else
        begin : g_body
            assign left_keep  = cell_keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        pq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .here_valid  (here_valid),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Next count and the result of the accepted request.
    always_comb
    begin
        count_next  = count_reg;
        value_next  = '0;
        prio_next   = '0;
        status_next = ST_OK;
        if (opcode == OP_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next = count_reg - CW'(1);
                value_next = cell_entry[0].value;
                prio_next  = cell_entry[0].prio;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded only on acceptance so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= value_next;
            prio_reg   <= prio_next;
            status_reg <= status_next;
            occ_reg    <= 5'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule
